FILE: rtl/plb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package plb_pkg;

    localparam int LUX_W         = 32;
    localparam int BRI_W         = 7;
    localparam int PT_W          = LUX_W + BRI_W;
    localparam int MAG_W         = LUX_W + BRI_W;
    localparam int QW            = BRI_W;
    localparam int CFG_IDX_W     = 3;
    localparam int ACT_W         = 3;
    localparam int MAX_POINTS_DEF = 5;
    localparam int MID_DEPTH_DEF  = 4;
    localparam int OUT_DEPTH_DEF  = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
    localparam logic [ACT_W-1:0]     ACTIVE_RESET = 3'd5;

    // job handed from classifier to divider
    typedef struct packed {
        logic             err;
        logic             direct;
        logic             neg;
        logic [BRI_W-1:0] dval;
        logic [MAG_W-1:0] mag;
        logic [LUX_W-1:0] den;
    } job_t;

    typedef struct packed {
        logic             err;
        logic [BRI_W-1:0] bri;
    } res_t;

    // reset curve: (0,20) (12800,40) (51200,70) (128000,90) (256000,100), last repeats
    function automatic logic [PT_W-1:0] default_point(input int i);
        logic [PT_W-1:0] p;
        begin
            unique case (i)
                0:       p = 39'd85899345920;
                1:       p = 39'd171798704640;
                2:       p = 39'd300647761920;
                3:       p = 39'd386547184640;
                default: p = 39'd429496985600;
            endcase
            return p;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/plb_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module plb_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [W-1:0]               din,
    input  wire logic                       pop,
    output logic [W-1:0]                    dout,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  mem [0:DEPTH-1];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_pop;

    assign do_pop = pop && (cnt_reg != '0);
    assign empty  = (cnt_reg == '0);
    assign count  = cnt_reg;
    assign dout   = mem[rd_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + AW'(1);
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/plb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module plb_front #(
    parameter int MAX_POINTS = plb_pkg::MAX_POINTS_DEF,
    parameter int MID_DEPTH  = plb_pkg::MID_DEPTH_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        push,
    output logic                                             full,
    input  wire logic signed [plb_pkg::LUX_W-1:0]            lux_sample,
    input  wire logic [MAX_POINTS-1:0][plb_pkg::PT_W-1:0]    pts,
    input  wire logic [plb_pkg::ACT_W-1:0]                   active_points,
    input  wire logic [$clog2(MID_DEPTH+1)-1:0]              mid_count,
    output logic                                             mid_push,
    output plb_pkg::job_t                                    mid_din,
    output logic [1:0]                                       inflight
);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int LW    = plb_pkg::LUX_W;
    localparam int BW    = plb_pkg::BRI_W;

    logic [IDX_W-1:0] last;
    logic [LW-1:0]    x;
    logic             found;
    logic [IDX_W-1:0] seg;
    logic             c_direct;
    logic             c_err;
    logic [BW-1:0]    c_dval;

    logic             s1_vld_reg;
    logic [LW-1:0]    s1_x_reg;
    logic [IDX_W-1:0] s1_seg_reg;
    logic             s1_direct_reg;
    logic             s1_err_reg;
    logic [BW-1:0]    s1_dval_reg;

    logic             s2_vld_reg;
    plb_pkg::job_t    s2_job_reg, s2_job_next;

    logic [LW-1:0]    x1, x2;
    logic [BW-1:0]    y1, y2;
    logic [BW-1:0]    absdy;
    logic [LW-1:0]    dx;

    assign inflight = {1'b0, s1_vld_reg} + {1'b0, s2_vld_reg};
    assign full     = (32'(mid_count) + 32'(inflight)) >= MID_DEPTH;
    assign mid_push = s2_vld_reg;
    assign mid_din  = s2_job_reg;

    // clamp the point count to the supported range
    always_comb
    begin
        priority if (active_points < 3'd2)
        begin
            last = IDX_W'(1);
        end
        else if (32'(active_points) > MAX_POINTS)
        begin
            last = IDX_W'(MAX_POINTS-1);
        end
        else
        begin
            last = IDX_W'(active_points - 3'd1);
        end
    end

    // classify: error on negative, clamp low, clamp high, or pick the first segment
    always_comb
    begin
        x     = {1'b0, lux_sample[LW-2:0]};
        found = 1'b0;
        seg   = '0;
        for (int i = 0; i < MAX_POINTS-1; i++)
        begin
            if (!found && (IDX_W'(i) < last) && (x <= pts[i+1][LW-1:0]))
            begin
                found = 1'b1;
                seg   = IDX_W'(i);
            end
        end
        c_err    = 1'b0;
        c_direct = 1'b1;
        c_dval   = pts[last][plb_pkg::PT_W-1:LW];
        priority if (lux_sample[LW-1])
        begin
            c_err  = 1'b1;
            c_dval = '0;
        end
        else if (x <= pts[0][LW-1:0])
        begin
            c_dval = pts[0][plb_pkg::PT_W-1:LW];
        end
        else if (x >= pts[last][LW-1:0])
        begin
            c_dval = pts[last][plb_pkg::PT_W-1:LW];
        end
        else if (found)
        begin
            c_direct = 1'b0;
        end
    end

    // segment endpoints and numerator
    always_comb
    begin
        x1    = pts[s1_seg_reg][LW-1:0];
        x2    = pts[s1_seg_reg + IDX_W'(1)][LW-1:0];
        y1    = pts[s1_seg_reg][plb_pkg::PT_W-1:LW];
        y2    = pts[s1_seg_reg + IDX_W'(1)][plb_pkg::PT_W-1:LW];
        dx    = s1_x_reg - x1;
        absdy = (y2 < y1) ? (y1 - y2) : (y2 - y1);
        s2_job_next.err    = s1_err_reg;
        s2_job_next.direct = 1'b1;
        s2_job_next.neg    = (y2 < y1);
        s2_job_next.dval   = s1_dval_reg;
        s2_job_next.mag    = plb_pkg::MAG_W'(dx) * plb_pkg::MAG_W'(absdy);
        s2_job_next.den    = x2 - x1;
        if (!s1_direct_reg)
        begin
            priority if (s1_x_reg <= x1)
            begin
                s2_job_next.dval = y1;
            end
            else if (s1_x_reg >= x2)
            begin
                s2_job_next.dval = y2;
            end
            else
            begin
                s2_job_next.direct = 1'b0;
                s2_job_next.dval   = y1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= push && !full;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg      <= x;
        s1_seg_reg    <= seg;
        s1_direct_reg <= c_direct;
        s1_err_reg    <= c_err;
        s1_dval_reg   <= c_dval;
        s2_job_reg    <= s2_job_next;
    end

endmodule
`default_nettype wire

FILE: rtl/plb_back.sv
`timescale 1ns / 1ps
`default_nettype none
module plb_back #(
    parameter int OUT_DEPTH = plb_pkg::OUT_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                mid_empty,
    input  wire plb_pkg::job_t                       mid_dout,
    output logic                                     mid_pop,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0]      out_count,
    output logic                                     out_push,
    output plb_pkg::res_t                            out_din,
    output logic [plb_pkg::QW:0]                     stage_vld
);
    localparam int QW = plb_pkg::QW;
    localparam int MW = plb_pkg::MAG_W;

    logic [QW:0]      vld_reg;
    plb_pkg::job_t    st_reg  [0:QW];
    plb_pkg::job_t    st_next [0:QW];
    logic [QW-1:0]    q_reg   [0:QW];
    logic [QW-1:0]    q_next  [0:QW];
    logic [MW-1:0]    trial   [0:QW-1];
    logic [QW-1:0]    q_up;

    assign stage_vld = vld_reg;
    // issue only with a guaranteed slot in the result queue
    assign mid_pop   = !mid_empty &&
                       ((32'(out_count) + $countones(vld_reg)) < OUT_DEPTH);
    assign out_push  = vld_reg[QW];

    // shifted divisor per quotient bit
    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            trial[k] = MW'(st_reg[k].den) << (QW-1-k);
        end
    end

    // restoring divider, one quotient bit per stage
    always_comb
    begin
        st_next[0] = mid_dout;
        q_next[0]  = '0;
        for (int k = 0; k < QW; k++)
        begin
            st_next[k+1] = st_reg[k];
            q_next[k+1]  = q_reg[k];
            if (st_reg[k].mag >= trial[k])
            begin
                st_next[k+1].mag    = st_reg[k].mag - trial[k];
                q_next[k+1][QW-1-k] = 1'b1;
            end
        end
    end

    // floor division result: round magnitude up on a negative slope
    always_comb
    begin
        q_up = q_reg[QW] + QW'(st_reg[QW].mag != '0);
        out_din.err = st_reg[QW].err;
        priority if (st_reg[QW].direct)
        begin
            out_din.bri = st_reg[QW].dval;
        end
        else if (st_reg[QW].neg)
        begin
            out_din.bri = st_reg[QW].dval - q_up;
        end
        else
        begin
            out_din.bri = st_reg[QW].dval + q_reg[QW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[QW-1:0], mid_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= QW; k++)
        begin
            st_reg[k] <= st_next[k];
            q_reg[k]  <= q_next[k];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/piecewise_linear_lux_to_brightness.sv
`timescale 1ns / 1ps
`default_nettype none
// Lux to brightness mapper. Samples are pushed one per cycle while full is
// low; each one yields a single result in order on the result queue, after
// two classify stages (segment search, then difference and multiply), a
// 4-entry job queue, a 7-stage pipelined divider with one quotient bit per
// stage, and a 16-entry result queue. Throughput is one sample per cycle
// when results are popped as fast. The user must write curve registers over
// the cfg port only while the block is idle; the block does not enforce it.
module piecewise_linear_lux_to_brightness #(
    parameter int MAX_POINTS = plb_pkg::MAX_POINTS_DEF,
    parameter int MID_DEPTH  = plb_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH  = plb_pkg::OUT_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic signed [plb_pkg::LUX_W-1:0]   lux_sample,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [plb_pkg::BRI_W-1:0]               brightness_pct,
    output logic                                    error_flag,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [plb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [plb_pkg::PT_W-1:0]           cfg_data
);
    logic [plb_pkg::ACT_W-1:0]              active_reg;
    logic [MAX_POINTS-1:0][plb_pkg::PT_W-1:0] pts_reg;

    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic                           mid_push, mid_pop, mid_empty;
    plb_pkg::job_t                  mid_din, mid_dout;
    logic [1:0]                     front_inflight;

    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic                           out_push;
    plb_pkg::res_t                  out_din, out_dout;
    logic [plb_pkg::QW:0]           back_vld;

    assign cfg_ready      = 1'b1;
    assign brightness_pct = out_dout.bri;
    assign error_flag     = out_dout.err;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= plb_pkg::ACTIVE_RESET;
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                pts_reg[i] <= plb_pkg::default_point(i);
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == plb_pkg::REG_ACTIVE)
            begin
                active_reg <= cfg_data[plb_pkg::ACT_W-1:0];
            end
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                if (32'(cfg_index) == i + 1)
                begin
                    pts_reg[i] <= cfg_data;
                end
            end
        end
    end

    plb_front #(
        .MAX_POINTS (MAX_POINTS),
        .MID_DEPTH  (MID_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .lux_sample    (lux_sample),
        .pts           (pts_reg),
        .active_points (active_reg),
        .mid_count     (mid_count),
        .mid_push      (mid_push),
        .mid_din       (mid_din),
        .inflight      (front_inflight)
    );

    plb_fifo #(
        .W     ($bits(plb_pkg::job_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (mid_din),
        .pop   (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty),
        .count (mid_count)
    );

    plb_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_dout  (mid_dout),
        .mid_pop   (mid_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_din   (out_din),
        .stage_vld (back_vld)
    );

    plb_fifo #(
        .W     ($bits(plb_pkg::res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_din),
        .pop   (pop),
        .dout  (out_dout),
        .empty (empty),
        .count (out_count)
    );

`ifndef NO_ASSERTIONS
    // job queue credit never oversubscribed
    a_mid_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(mid_count) + 32'(front_inflight)) <= MID_DEPTH)
        else $error("job queue credit overrun");

    // result queue has room for everything in the divider
    a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(out_count) + $countones(back_vld)) <= OUT_DEPTH)
        else $error("result queue credit overrun");

    // an error result carries zero brightness
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error_flag) |-> (brightness_pct == '0))
        else $error("error result with nonzero brightness");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int LUX_W     = plb_pkg::LUX_W;
    localparam int BRI_W     = plb_pkg::BRI_W;
    localparam int PT_W      = plb_pkg::PT_W;
    localparam int CFG_IDX_W = plb_pkg::CFG_IDX_W;
    localparam int ACT_W     = plb_pkg::ACT_W;

    localparam int NPTS = 5;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 30;
    localparam logic [CFG_IDX_W-1:0] REG_POINT0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST = 3'd7;

    typedef struct {
        logic signed [LUX_W-1:0] lux;
        bit                      known;
        logic [BRI_W-1:0]        bri;
        bit                      err;
    } lux_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        full;
    logic signed [LUX_W-1:0]     lux_sample = '0;
    logic                        empty;
    logic                        pop = 1'b0;
    logic [BRI_W-1:0]            brightness_pct;
    logic                        error_flag;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [PT_W-1:0]             cfg_data = '0;

    // shadow of the curve registers
    logic [ACT_W-1:0] curve_active;
    logic [PT_W-1:0]  curve_pts[NPTS];

    plb_pkg::res_t pending_levels[$];
    int   fail_cnt = 0;
    bit   hold_req = 1'b0;
    int   idle_cycles = 0;

    piecewise_linear_lux_to_brightness i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .lux_sample     (lux_sample),
        .empty          (empty),
        .pop            (pop),
        .brightness_pct (brightness_pct),
        .error_flag     (error_flag),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [LUX_W-1:0] lux_at(input int i);
        return curve_pts[i][LUX_W-1:0];
    endfunction

    function automatic longint bri_at(input int i);
        return longint'(curve_pts[i][PT_W-1:LUX_W]);
    endfunction

    // expected brightness for one sample under the current curve
    function automatic plb_pkg::res_t map_lux(input logic signed [LUX_W-1:0] s);
        plb_pkg::res_t r;
        int n;
        int last;
        bit hit;
        longint x;
        longint x1;
        longint x2;
        longint y1;
        longint y2;
        longint num;
        longint den;
        longint q;
        longint level;
        begin
            n = curve_active;
            if (n < 2) n = 2;
            if (n > NPTS) n = NPTS;
            last = n - 1;
            r.err = 1'b0;
            if (s[LUX_W-1])
            begin
                r.err = 1'b1;
                r.bri = '0;
                return r;
            end
            x = longint'({1'b0, s});
            if (x <= longint'(lux_at(0)))
                level = bri_at(0);
            else if (x >= longint'(lux_at(last)))
                level = bri_at(last);
            else
            begin
                level = bri_at(last);
                hit = 1'b0;
                for (int i = 0; i < last; i++)
                begin
                    if (!hit && x <= longint'(lux_at(i + 1)))
                    begin
                        hit = 1'b1;
                        x1 = longint'(lux_at(i));
                        x2 = longint'(lux_at(i + 1));
                        y1 = bri_at(i);
                        y2 = bri_at(i + 1);
                        if (x <= x1)
                            level = y1;
                        else if (x >= x2)
                            level = y2;
                        else
                        begin
                            num = (x - x1) * (y2 - y1);
                            den = x2 - x1;
                            // floor division, numerator may be negative
                            if (num >= 0) q = num / den;
                            else q = -((-num + den - 1) / den);
                            level = y1 + q;
                        end
                    end
                end
            end
            r.bri = level[BRI_W-1:0];
            return r;
        end
    endfunction

    // one sample transaction; push stays high for the caller to lower
    task automatic send_lux(input logic signed [LUX_W-1:0] s);
        push <= 1'b1;
        lux_sample <= s;
        do @(posedge clk); while (full);
        pending_levels.push_back(map_lux(s));
    endtask

    task automatic sender_gap();
        int g;
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                g = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 3);
                push <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    endtask

    // one register write; valid is lowered by the caller
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == plb_pkg::REG_ACTIVE)
            curve_active = val[ACT_W-1:0];
        else if (idx <= NPTS)
            curve_pts[idx - 1] = val;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_levels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PT_W-1:0] make_point(input logic [31:0] lx, input int b);
        return {b[BRI_W-1:0], lx};
    endfunction

    // new curve for one phase; mode picks sorted, extreme, unsorted or raw bits
    task automatic load_curve(input int ph);
        logic [PT_W-1:0] p[NPTS];
        logic [31:0] lx;
        int mode;
        begin
            mode = ph % 4;
            lx = $urandom_range(0, 2000);
            for (int i = 0; i < NPTS; i++)
            begin
                case (mode)
                    0:
                    begin
                        p[i] = make_point(lx, $urandom_range(0, 127));
                        lx = lx + $urandom_range(1, 100000);
                    end
                    1:
                    begin
                        // extremes of lux and brightness
                        p[i] = make_point((i == 0) ? 32'h0 : (i == NPTS - 1) ? 32'hFFFF_FFFF
                                          : 32'h4000_0000 * i, (i % 2) ? 127 : 0);
                    end
                    2: p[i] = make_point($urandom_range(0, 300000), $urandom_range(0, 127));
                    default: p[i] = PT_W'({$urandom, $urandom});
                endcase
            end
            for (int i = 0; i < NPTS; i++)
                write_reg(CFG_IDX_W'(REG_POINT0 + i), p[i]);
            // indexes past the list must be ignored
            write_reg(CFG_IDX_W'(REG_POINT0 + NPTS), PT_W'({$urandom, $urandom}));
            write_reg(REG_LAST, PT_W'({$urandom, $urandom}));
            write_reg(plb_pkg::REG_ACTIVE, PT_W'(ph % 8));
            cfg_valid <= 1'b0;
        end
    endtask

    function automatic logic signed [LUX_W-1:0] pick_lux();
        int k;
        int i;
        logic [31:0] hi;
        begin
            k = $urandom_range(0, 9);
            i = $urandom_range(0, NPTS - 1);
            hi = 0;
            for (int j = 0; j < NPTS; j++)
                if (lux_at(j) > hi) hi = lux_at(j);
            case (k)
                0: return $urandom;
                1: return -$signed({1'b0, 31'($urandom)}) - 1;
                2, 3: return lux_at(i) + $urandom_range(0, 4) - 2;
                default: return $urandom_range(0, hi);
            endcase
        end
    endfunction

    lux_row_t lux_rows[14] = '{
        '{32'sd0,          1, 7'd20,  0},
        '{32'h7FFF_FFFF,   1, 7'd100, 0},
        '{32'h8000_0000,   1, 7'd0,   1},
        '{-32'sd1,         1, 7'd0,   1},
        '{32'sd12800,      1, 7'd40,  0},
        '{32'sd51200,      1, 7'd70,  0},
        '{32'sd128000,     1, 7'd90,  0},
        '{32'sd256000,     1, 7'd100, 0},
        '{32'sd300000,     1, 7'd100, 0},
        '{32'sd1,          0, 7'd0,   0},
        '{32'sd6400,       0, 7'd0,   0},
        '{32'sd200000,     0, 7'd0,   0},
        '{32'sd12801,      0, 7'd0,   0},
        '{32'h4000_0000,   0, 7'd0,   0}
    };

    // stimulus
    initial
    begin
        curve_active = plb_pkg::ACTIVE_RESET;
        for (int i = 0; i < NPTS; i++) curve_pts[i] = plb_pkg::default_point(i);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows against the reset curve
        foreach (lux_rows[r])
        begin
            send_lux(lux_rows[r].lux);
            if (lux_rows[r].known)
            begin
                pending_levels[$].bri = lux_rows[r].bri;
                pending_levels[$].err = lux_rows[r].err;
            end
        end
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            load_curve(ph);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 2 && n == 20) hold_req = 1'b1;
                send_lux(pick_lux());
                sender_gap();
            end
            wait_drained();
        end

        if (fail_cnt == 0)
            $display("piecewise_linear_lux_to_brightness: match");
        else
            $display("piecewise_linear_lux_to_brightness: mismatch");
        $finish;
    end

    // result side: check and random pop stalls
    initial
    begin
        int stall;
        plb_pkg::res_t want;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_levels.size() == 0)
                begin
                    $display("%0t: unexpected result bri=%0d err=%0b", $time,
                             brightness_pct, error_flag);
                    fail_cnt++;
                end
                else
                begin
                    want = pending_levels.pop_front();
                    if (want.bri !== brightness_pct || want.err !== error_flag)
                    begin
                        $display("%0t: expected bri=%0d err=%0b, got bri=%0d err=%0b",
                                 $time, want.bri, want.err, brightness_pct, error_flag);
                        fail_cnt++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = 300;
            end
            else if (stall == 0 && $urandom_range(0, 5) == 0)
                stall = ($urandom_range(0, 20) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 3);
            if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else
                pop <= rst_n;
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("piecewise_linear_lux_to_brightness: mismatch");
            $finish;
        end
    end

endmodule

FILE: piecewise_linear_lux_to_brightness.f
rtl/plb_pkg.sv
rtl/plb_fifo.sv
rtl/plb_front.sv
rtl/plb_back.sv
rtl/piecewise_linear_lux_to_brightness.sv
tb/tb.sv
